// ===== rtl/logistic_poly_sigmoid_classifier_defines.svh =====
// Assertion macros shared by the classifier RTL.
`ifndef LOGISTIC_POLY_SIGMOID_CLASSIFIER_DEFINES_SVH
`define LOGISTIC_POLY_SIGMOID_CLASSIFIER_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define LPS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define LPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/lps_pkg.sv =====
package lps_pkg;

  // Item command codes
  localparam logic CMD_WEIGHT  = 1'b0;
  localparam logic CMD_FEATURE = 1'b1;

  // Polynomial coefficients in Q.32
  localparam logic [33:0] COEF1_Q32 = 34'd6573361547;
  localparam logic [33:0] COEF3_Q32 = 34'd10107370590;
  localparam logic [33:0] COEF5_Q32 = 34'd5803057015;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_TLIM,
    S_POLY_GO,
    S_POLY_WAIT,
    S_DIFF,
    S_SAT,
    S_OUT
  } lps_state_e;

  // Polynomial product steps, in issue order
  typedef enum logic [2:0] {
    OP_T2,
    OP_T3,
    OP_T5,
    OP_M1,
    OP_M3,
    OP_M5
  } lps_op_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic    wt_write;
    logic    feat_load;
    logic    mac_mul;
    logic    mac_add;
    logic    t_load;
    logic    mul_start;
    logic    mul_store;
    logic    diff_load;
    logic    sat_load;
    logic    out_load;
    lps_op_e op;
  } lps_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic mul_done;
  } lps_sts_t;

endpackage

// ===== rtl/lps_mul.sv =====
module lps_mul import lps_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        frac_shift_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] result_o
);

  logic [63:0]  a_q, b_q;
  logic         frac_q;
  logic         busy_q;
  logic [2:0]   cnt_q;
  logic         done_q;
  logic [63:0]  pp_q, pp_d;
  logic [1:0]   ppsh_q, ppsh_d;
  logic [127:0] acc_q;
  logic [127:0] pp_aligned;
  logic [31:0]  a_part, b_part;

  // Pick the 32-bit halves for this partial product
  always_comb begin
    a_part = cnt_q[1] ? a_q[63:32] : a_q[31:0];
    b_part = cnt_q[0] ? b_q[63:32] : b_q[31:0];
    pp_d   = 64'(a_part) * 64'(b_part);
    ppsh_d = 2'({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]});
  end

  // Align the registered partial product by its word weight
  always_comb begin
    case (ppsh_q)
      2'd0:    pp_aligned = {64'd0, pp_q};
      2'd1:    pp_aligned = {32'd0, pp_q, 32'd0};
      2'd2:    pp_aligned = {pp_q, 64'd0};
      default: pp_aligned = '0;
    endcase
  end

  // Advance the partial-product sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Hold operands, partial product and running sum
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q    <= a_i;
      b_q    <= b_i;
      frac_q <= frac_shift_i;
      acc_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q != 3'd4) begin
        pp_q   <= pp_d;
        ppsh_q <= ppsh_d;
      end
      if (cnt_q != 3'd0) begin
        acc_q <= acc_q + pp_aligned;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = frac_q ? acc_q[FRAC_BITS +: 64] : acc_q[32 +: 64];

endmodule

// ===== rtl/lps_dp.sv =====
module lps_dp import lps_pkg::*; #(
  parameter int MAX_FEATURES = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lps_cmd_t           cmd_i,
  output lps_sts_t           sts_o,
  input  logic [3:0]         index_i,
  input  logic signed [31:0] value_i,
  input  logic               label_positive_i,
  output logic signed [31:0] prob_o,
  output logic               pred_positive_o,
  output logic               match_o,
  output logic [31:0]        correct_count_o,
  output logic [31:0]        sample_count_o
);

  localparam int AW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  // Magnitude widths: |t| <= 64 in Q.F, powers and terms follow from it
  localparam int TW  = FRAC_BITS + 7;
  localparam int T2W = FRAC_BITS + 13;
  localparam int T3W = FRAC_BITS + 19;
  localparam int T5W = FRAC_BITS + 31;
  localparam int M1W = FRAC_BITS + 8;
  localparam int M3W = FRAC_BITS + 20;
  localparam int M5W = FRAC_BITS + 31;

  localparam logic signed [63:0] TLIM    = 64'sd64 <<< FRAC_BITS;
  localparam logic signed [63:0] HALF    = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] P_MAX   = 64'sd2147483647;
  localparam logic signed [63:0] P_MIN   = -64'sd2147483648;
  localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] ACC_MIN = {1'b1, 63'd0};

  logic signed [31:0] wmem [MAX_FEATURES];
  logic [AW-1:0]      addr;
  logic               in_range;

  logic signed [31:0] w_q, feat_q;
  logic               in_range_q;
  logic               label_q;
  logic signed [63:0] prod_q, prod_d;
  logic signed [63:0] acc_q, acc_d;
  logic signed [64:0] sum65;

  logic signed [63:0] t_full, t_clamp, t_abs;
  logic [TW-1:0]      tmag_q;
  logic               tneg_q;
  logic [T2W-1:0]     t2_q;
  logic [T3W-1:0]     t3_q;
  logic [T5W-1:0]     t5_q;
  logic [M1W-1:0]     m1_q;
  logic [M3W-1:0]     m3_q;
  logic [M5W-1:0]     m5_q;
  logic signed [63:0] diff_q, diff_d;
  logic signed [63:0] p_v;
  logic signed [31:0] psat_q, psat_d;
  logic               pred_q, pred_d;

  logic [63:0] mul_a, mul_b, mul_res;
  logic        mul_frac, mul_done;

  logic signed [31:0] prob_q;
  logic               pred_out_q, match_q;
  logic [31:0]        correct_q, sample_q;
  logic               match_d;

  assign addr     = AW'(index_i);
  assign in_range = 32'(index_i) < MAX_FEATURES;

  // Write weights and read the weight for a feature
  always_ff @(posedge clk_i) begin
    if (cmd_i.wt_write && in_range) begin
      wmem[addr] <= value_i;
    end
    if (cmd_i.feat_load) begin
      w_q <= wmem[addr];
    end
  end

  // Latch the feature fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.feat_load) begin
      feat_q     <= value_i;
      in_range_q <= in_range;
      label_q    <= label_positive_i;
    end
  end

  // Multiply feature by weight
  always_comb begin
    prod_d = in_range_q ? w_q * feat_q : 64'sd0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_mul) begin
      prod_q <= prod_d;
    end
  end

  // Accumulate with saturation
  always_comb begin
    sum65 = {acc_q[63], acc_q} + {prod_q[63], prod_q};
    if (sum65[64] != sum65[63]) begin
      acc_d = sum65[64] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_d = sum65[63:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (cmd_i.t_load) begin
      acc_q <= '0;
    end else if (cmd_i.mac_add) begin
      acc_q <= acc_d;
    end
  end

  // Scale by 1/8, clamp and split into sign and magnitude
  always_comb begin
    t_full = acc_q >>> (FRAC_BITS + 3);
    if (t_full > TLIM) begin
      t_clamp = TLIM;
    end else if (t_full < -TLIM) begin
      t_clamp = -TLIM;
    end else begin
      t_clamp = t_full;
    end
    t_abs = t_clamp[63] ? -t_clamp : t_clamp;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.t_load) begin
      tmag_q <= t_abs[TW-1:0];
      tneg_q <= t_clamp[63];
    end
  end

  // Select operands for the shared multiplier
  always_comb begin
    mul_frac = 1'b1;
    case (cmd_i.op)
      OP_T2: begin
        mul_a = 64'(tmag_q);
        mul_b = 64'(tmag_q);
      end
      OP_T3: begin
        mul_a = 64'(t2_q);
        mul_b = 64'(tmag_q);
      end
      OP_T5: begin
        mul_a = 64'(t3_q);
        mul_b = 64'(t2_q);
      end
      OP_M1: begin
        mul_a    = 64'(COEF1_Q32);
        mul_b    = 64'(tmag_q);
        mul_frac = 1'b0;
      end
      OP_M3: begin
        mul_a    = 64'(COEF3_Q32);
        mul_b    = 64'(t3_q);
        mul_frac = 1'b0;
      end
      OP_M5: begin
        mul_a    = 64'(COEF5_Q32);
        mul_b    = 64'(t5_q);
        mul_frac = 1'b0;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  lps_mul #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.mul_start),
    .frac_shift_i(mul_frac),
    .a_i         (mul_a),
    .b_i         (mul_b),
    .done_o      (mul_done),
    .result_o    (mul_res)
  );

  assign sts_o.mul_done = mul_done;

  // Store each product magnitude
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_store) begin
      case (cmd_i.op)
        OP_T2:   t2_q <= mul_res[T2W-1:0];
        OP_T3:   t3_q <= mul_res[T3W-1:0];
        OP_T5:   t5_q <= mul_res[T5W-1:0];
        OP_M1:   m1_q <= mul_res[M1W-1:0];
        OP_M3:   m3_q <= mul_res[M3W-1:0];
        OP_M5:   m5_q <= mul_res[M5W-1:0];
        default: ;
      endcase
    end
  end

  // Combine odd terms; all share the sign of t
  always_comb begin
    diff_d = signed'(64'(m3_q)) - signed'(64'(m1_q)) - signed'(64'(m5_q));
    p_v    = HALF + (tneg_q ? -diff_q : diff_q);
    if (p_v > P_MAX) begin
      psat_d = 32'h7fff_ffff;
    end else if (p_v < P_MIN) begin
      psat_d = 32'h8000_0000;
    end else begin
      psat_d = p_v[31:0];
    end
    pred_d  = p_v >= HALF;
    match_d = pred_q == label_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff_load) begin
      diff_q <= diff_d;
    end
    if (cmd_i.sat_load) begin
      psat_q <= psat_d;
      pred_q <= pred_d;
    end
  end

  // Load the output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      prob_q     <= psat_q;
      pred_out_q <= pred_q;
      match_q    <= match_d;
    end
  end

  // Count samples and correct predictions, sticking at full scale
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q  <= '0;
      correct_q <= '0;
    end else if (cmd_i.out_load) begin
      if (sample_q != '1) begin
        sample_q <= sample_q + 32'd1;
      end
      if (match_d && correct_q != '1) begin
        correct_q <= correct_q + 32'd1;
      end
    end
  end

  assign prob_o          = prob_q;
  assign pred_positive_o = pred_out_q;
  assign match_o         = match_q;
  assign correct_count_o = correct_q;
  assign sample_count_o  = sample_q;

endmodule

// ===== rtl/lps_ctrl.sv =====
module lps_ctrl import lps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     cmd_i,
  input  logic     last_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output lps_cmd_t dp_cmd_o,
  input  lps_sts_t dp_sts_i
);

  lps_state_e state_q, state_d;
  lps_op_e    op_q, op_d;
  logic       last_q, last_d;
  logic       out_valid_q, out_valid_d;
  logic       in_accept;

  // Hold state, step and output flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_T2;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    dp_cmd_o    = '0;
    dp_cmd_o.op = op_q;
    in_accept   = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        in_accept  = in_valid_i;
        if (in_accept) begin
          if (cmd_i == CMD_FEATURE) begin
            dp_cmd_o.feat_load = 1'b1;
            last_d             = last_i;
            state_d            = S_MUL;
          end else begin
            dp_cmd_o.wt_write = 1'b1;
          end
        end
      end
      S_MUL: begin
        dp_cmd_o.mac_mul = 1'b1;
        state_d          = S_ACC;
      end
      S_ACC: begin
        dp_cmd_o.mac_add = 1'b1;
        state_d          = last_q ? S_TLIM : S_IDLE;
      end
      S_TLIM: begin
        dp_cmd_o.t_load = 1'b1;
        op_d            = OP_T2;
        state_d         = S_POLY_GO;
      end
      S_POLY_GO: begin
        dp_cmd_o.mul_start = 1'b1;
        state_d            = S_POLY_WAIT;
      end
      S_POLY_WAIT: begin
        if (dp_sts_i.mul_done) begin
          dp_cmd_o.mul_store = 1'b1;
          state_d            = S_POLY_GO;
          case (op_q)
            OP_T2:   op_d = OP_T3;
            OP_T3:   op_d = OP_T5;
            OP_T5:   op_d = OP_M1;
            OP_M1:   op_d = OP_M3;
            OP_M3:   op_d = OP_M5;
            default: state_d = S_DIFF;
          endcase
        end
      end
      S_DIFF: begin
        dp_cmd_o.diff_load = 1'b1;
        state_d            = S_SAT;
      end
      S_SAT: begin
        dp_cmd_o.sat_load = 1'b1;
        state_d           = S_OUT;
      end
      S_OUT: begin
        // Wait for the output register to drain
        if (!out_valid_q || out_ready_i) begin
          dp_cmd_o.out_load = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/logistic_poly_sigmoid_classifier.sv =====
// Channel  Handshake                 Payload
// in       in_valid_i / in_ready_o   cmd_i index_i value_i last_i label_positive_i
// out      out_valid_o / out_ready_i prob_o pred_positive_o match_o
//                                     correct_count_o sample_count_o
//
// A weight item is written from S_IDLE; a feature item passes weight read, multiply and
// accumulate. A last feature adds six polynomial products through one shared
// 32x32 multiplier, four partial products each, then combine and saturate.
// Reset clears the accumulator, counts and control; the weight table is not cleared.
// A finished result waits in the output register while new items are taken; the
// next result stalls only if that register is still full.
`include "logistic_poly_sigmoid_classifier_defines.svh"

module logistic_poly_sigmoid_classifier import lps_pkg::*; #(
  parameter int MAX_FEATURES = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [3:0]         index_i,
  input  logic signed [31:0] value_i,
  input  logic               last_i,
  input  logic               label_positive_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] prob_o,
  output logic               pred_positive_o,
  output logic               match_o,
  output logic [31:0]        correct_count_o,
  output logic [31:0]        sample_count_o
);

  localparam logic signed [31:0] HALF = 32'sd1 <<< (FRAC_BITS - 1);

  lps_cmd_t dp_cmd;
  lps_sts_t dp_sts;

  lps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .dp_cmd_o   (dp_cmd),
    .dp_sts_i   (dp_sts)
  );

  lps_dp #(
    .MAX_FEATURES(MAX_FEATURES),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (dp_cmd),
    .sts_o           (dp_sts),
    .index_i         (index_i),
    .value_i         (value_i),
    .label_positive_i(label_positive_i),
    .prob_o          (prob_o),
    .pred_positive_o (pred_positive_o),
    .match_o         (match_o),
    .correct_count_o (correct_count_o),
    .sample_count_o  (sample_count_o)
  );

  `LPS_ASSERT_SAME(a_counts_order, clk_i, rst_ni, out_valid_o, correct_count_o <= sample_count_o, "correct count exceeds sample count")
  `LPS_ASSERT_SAME(a_pred_consistent, clk_i, rst_ni, out_valid_o, pred_positive_o == (prob_o >= HALF), "prediction disagrees with probability")
  `LPS_ASSERT_NEXT(a_count_steps, clk_i, rst_ni, dp_cmd.out_load && sample_count_o != '1, sample_count_o == $past(sample_count_o) + 32'd1, "sample count did not advance")

endmodule

// ===== bench/logistic_poly_sigmoid_classifier_test.sv =====
`timescale 1ns / 1ps

module logistic_poly_sigmoid_classifier_test;
  import lps_pkg::*;

  localparam int FRAC = 16;
  localparam int RANDOM_ITEMS = 450;
  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT = 2000;

  // Sigmoid polynomial coefficients in Q.32
  localparam logic signed [63:0] COEF_T1 = 64'sd6573361547;
  localparam logic signed [63:0] COEF_T3 = 64'sd10107370590;
  localparam logic signed [63:0] COEF_T5 = 64'sd5803057015;
  localparam logic signed [63:0] HALF_Q16 = 64'sd32768;
  localparam logic signed [63:0] T_BOUND = 64'sd4194304;
  localparam logic signed [63:0] PROB_MAX = 64'sd2147483647;
  localparam logic signed [63:0] PROB_MIN = 64'shFFFF_FFFF_8000_0000;
  localparam logic signed [63:0] DOT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] DOT_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic signed [31:0] prob;
    logic               pred;
    logic               match;
    logic [31:0]        correct;
    logic [31:0]        samples;
  } score_t;

  typedef struct packed {
    logic        cmd;
    logic [3:0]  index;
    logic [31:0] value;
    logic        last;
    logic        label;
    logic        hand_checked;
    score_t      want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               item_cmd = CMD_WEIGHT;
  logic [3:0]         item_index = '0;
  logic signed [31:0] item_value = '0;
  logic               item_last = 1'b0;
  logic               item_label = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] score_prob;
  logic               score_pred;
  logic               score_match;
  logic [31:0]        score_correct;
  logic [31:0]        score_samples;

  logic               calm = 1'b0;
  int unsigned        mismatch_count = 0;
  int unsigned        stalled_cycles = 0;
  logic [15:0]        weight_written = '0;
  score_t             expected_scores[$];

  // Shadow copy of the scorer state
  logic signed [31:0] weight_shadow[16];
  logic signed [63:0] dot_shadow = '0;
  logic [31:0]        correct_shadow = '0;
  logic [31:0]        sample_shadow = '0;

  // Directed items; hand-checked rows carry their expected score
  stim_row_t directed_rows[23] = '{
    '{CMD_WEIGHT,  4'd0,  32'h7FFF_FFFF, 1'b1, 1'b1, 1'b0, '0},
    '{CMD_WEIGHT,  4'd15, 32'h8000_0000, 1'b0, 1'b1, 1'b0, '0},
    '{CMD_WEIGHT,  4'd5,  32'h0001_0000, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_FEATURE, 4'd0,  32'h0000_0000, 1'b1, 1'b1, 1'b1,
      '{32'h0000_8000, 1'b1, 1'b1, 32'd1, 32'd1}},
    '{CMD_FEATURE, 4'd0,  32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1,
      '{32'h8000_0000, 1'b0, 1'b1, 32'd2, 32'd2}},
    '{CMD_FEATURE, 4'd15, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1,
      '{32'h7FFF_FFFF, 1'b1, 1'b0, 32'd2, 32'd3}},
    '{CMD_FEATURE, 4'd5,  32'h0001_0000, 1'b0, 1'b1, 1'b0, '0},
    '{CMD_FEATURE, 4'd5,  32'hFFFF_0000, 1'b1, 1'b1, 1'b1,
      '{32'h0000_8000, 1'b1, 1'b1, 32'd3, 32'd4}},
    // Positive accumulator overflow must stick at the top
    '{CMD_FEATURE, 4'd0,  32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_FEATURE, 4'd0,  32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_FEATURE, 4'd0,  32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_FEATURE, 4'd15, 32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1,
      '{32'h8000_0000, 1'b0, 1'b0, 32'd3, 32'd5}},
    // Negative accumulator overflow must stick at the bottom
    '{CMD_FEATURE, 4'd15, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_FEATURE, 4'd15, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_FEATURE, 4'd15, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_FEATURE, 4'd0,  32'h7FFF_FFFF, 1'b1, 1'b1, 1'b1,
      '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'd4, 32'd6}},
    '{CMD_FEATURE, 4'd15, 32'h8000_0000, 1'b1, 1'b1, 1'b1,
      '{32'h8000_0000, 1'b0, 1'b0, 32'd4, 32'd7}},
    '{CMD_WEIGHT,  4'd3,  32'h0000_8000, 1'b1, 1'b0, 1'b0, '0},
    '{CMD_FEATURE, 4'd3,  32'h0003_0000, 1'b1, 1'b0, 1'b0, '0},
    '{CMD_FEATURE, 4'd3,  32'hFFFA_0000, 1'b1, 1'b1, 1'b0, '0},
    '{CMD_WEIGHT,  4'd10, 32'hFFFF_F000, 1'b0, 1'b1, 1'b0, '0},
    '{CMD_FEATURE, 4'd10, 32'h0040_0000, 1'b0, 1'b0, 1'b0, '0},
    '{CMD_FEATURE, 4'd3,  32'h0001_0000, 1'b1, 1'b0, 1'b0, '0}
  };

  logistic_poly_sigmoid_classifier dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .cmd_i            (item_cmd),
    .index_i          (item_index),
    .value_i          (item_value),
    .last_i           (item_last),
    .label_positive_i (item_label),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .prob_o           (score_prob),
    .pred_positive_o  (score_pred),
    .match_o          (score_match),
    .correct_count_o  (score_correct),
    .sample_count_o   (score_samples)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // (a*b) >> shift on magnitudes, truncated toward zero, clipped to the int64 range
  function automatic logic signed [63:0] mul_trunc(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  input int unsigned shift);
    logic [63:0]  mag_a;
    logic [63:0]  mag_b;
    logic [63:0]  mag_r;
    logic [127:0] full;
    mag_a = a[63] ? -a : a;
    mag_b = b[63] ? -b : b;
    full = ({64'd0, mag_a} * {64'd0, mag_b}) >> shift;
    mag_r = (full[127:63] != '0) ? DOT_MAX : full[63:0];
    return (a[63] ^ b[63]) ? -$signed(mag_r) : $signed(mag_r);
  endfunction

  // Advance the shadow state by one item; produce a score on the last feature
  function automatic void score_item(input logic c, input logic [3:0] ix,
                                     input logic signed [31:0] v, input logic lst,
                                     input logic lab, output logic produced,
                                     output score_t s);
    logic signed [63:0] w64;
    logic signed [63:0] v64;
    logic signed [63:0] prod;
    logic signed [64:0] sum;
    logic signed [63:0] t;
    logic signed [63:0] t2;
    logic signed [63:0] t3;
    logic signed [63:0] t5;
    logic signed [63:0] p;
    produced = 1'b0;
    s = '0;
    if (c == CMD_WEIGHT) begin
      weight_shadow[ix] = v;
      return;
    end
    w64 = weight_shadow[ix];
    v64 = v;
    prod = w64 * v64;
    sum = dot_shadow + prod;
    if (sum[64] != sum[63]) begin
      dot_shadow = sum[64] ? DOT_MIN : DOT_MAX;
    end else begin
      dot_shadow = sum[63:0];
    end
    if (!lst) return;
    // Scale by 1/8 and clamp t to +-64
    t = dot_shadow >>> (FRAC + 3);
    if (t > T_BOUND) t = T_BOUND;
    if (t < -T_BOUND) t = -T_BOUND;
    t2 = mul_trunc(t, t, FRAC);
    t3 = mul_trunc(t2, t, FRAC);
    t5 = mul_trunc(t3, t2, FRAC);
    p = HALF_Q16 - mul_trunc(COEF_T1, t, 32) + mul_trunc(COEF_T3, t3, 32)
        - mul_trunc(COEF_T5, t5, 32);
    if (p > PROB_MAX) p = PROB_MAX;
    if (p < PROB_MIN) p = PROB_MIN;
    s.prob = p[31:0];
    s.pred = (p >= HALF_Q16);
    s.match = (s.pred == lab);
    if (sample_shadow != 32'hFFFF_FFFF) sample_shadow++;
    if (s.match && correct_shadow != 32'hFFFF_FFFF) correct_shadow++;
    dot_shadow = '0;
    s.correct = correct_shadow;
    s.samples = sample_shadow;
    produced = 1'b1;
  endfunction

  // Mostly small Q16.16 values so probabilities land near the threshold
  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 65) return 32'($urandom_range(524288)) - 32'd262144;
    if (r < 85) return $urandom;
    case ($urandom_range(4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'h0001_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Present one item, hold it until taken, then predict and maybe idle
  task automatic send_item(input logic c, input logic [3:0] ix, input logic [31:0] v,
                           input logic lst, input logic lab, input logic hand_checked,
                           input score_t hand_score);
    logic   produced;
    score_t predicted;
    item_cmd <= c;
    item_index <= ix;
    item_value <= v;
    item_last <= lst;
    item_label <= lab;
    in_valid <= 1'b1;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    score_item(c, ix, v, lst, lab, produced, predicted);
    if (produced) expected_scores.push_back(hand_checked ? hand_score : predicted);
    if (c == CMD_WEIGHT) weight_written[ix] = 1'b1;
    if (!calm && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      if ($urandom_range(99) < 80) begin
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        repeat ($urandom_range(4, 40)) @(posedge clk);
      end
    end
  endtask

  // Stall the result side at random, never during the calm stretch
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 12);
  end

  // Check results and watch for a hang
  always @(negedge clk) begin
    score_t got;
    score_t want;
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
    end
    if (out_valid && out_ready) begin
      got = '{score_prob, score_pred, score_match, score_correct, score_samples};
      if (expected_scores.size() == 0) begin
        $display("%0t: unexpected result: expected none, got prob %h", $time, got.prob);
        mismatch_count++;
      end else begin
        want = expected_scores.pop_front();
        check_field("prob", want.prob, got.prob);
        check_field("pred_positive", 32'(want.pred), 32'(got.pred));
        check_field("match", 32'(want.match), 32'(got.match));
        check_field("correct_count", want.correct, got.correct);
        check_field("sample_count", want.samples, got.samples);
      end
    end
    if (stalled_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned random_sent;
    int unsigned features_left;
    logic [3:0]  ix;
    random_sent = 0;
    features_left = 0;
    foreach (weight_shadow[i]) weight_shadow[i] = '0;

    // Hold reset, then release on a clock edge
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].cmd, directed_rows[i].index, directed_rows[i].value,
                directed_rows[i].last, directed_rows[i].label,
                directed_rows[i].hand_checked, directed_rows[i].want);
    end

    // Random samples of 1..5 features, with weight writes mixed in
    while (random_sent < RANDOM_ITEMS) begin
      calm = (random_sent >= 150 && random_sent < 260);
      if (features_left == 0) features_left = $urandom_range(1, 5);
      if ($urandom_range(99) < 12) begin
        send_item(CMD_WEIGHT, 4'($urandom_range(15)), pick_value(), 1'($urandom),
                  1'($urandom), 1'b0, '0);
      end else begin
        ix = 4'($urandom_range(15));
        while (!weight_written[ix]) ix = 4'($urandom_range(15));
        features_left--;
        send_item(CMD_FEATURE, ix, pick_value(), features_left == 0, 1'($urandom),
                  1'b0, '0);
      end
      random_sent++;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    // Drain outstanding scores, then give the block time to misbehave
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
